### rtl/core/assert_macros.svh
// Assertion macros shared by the point-in-polygon core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/pip_pkg.sv
// Types and constants of the point-in-polygon core.
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int COORD_W          = 32;
    localparam int IDX_W            = 6;
    localparam int COUNT_W          = 7;
    localparam int STAGES_PER_CELL  = 3;

    typedef enum logic [0:0] {
        MODE_LOAD = 1'b0,
        MODE_TEST = 1'b1
    } t_mode;

    // Control part of a query travelling down the chain.
    typedef struct packed {
        logic valid;
        logic parity;
        logic last;
    } t_tok;

    // Per-cell view of the vertex count.
    typedef struct packed {
        logic active;
        logic wrap;
    } t_cell_ctl;

endpackage

### rtl/core/pip_ifs.sv
// Channel interfaces of the point-in-polygon core.
interface pip_in_if;
    logic                               valid;
    logic                               ready;
    pip_pkg::t_mode                     mode;
    logic [pip_pkg::IDX_W-1:0]          vertex_index;
    logic signed [pip_pkg::COORD_W-1:0] coord_x;
    logic signed [pip_pkg::COORD_W-1:0] coord_y;
    logic                               last_point;

    modport source (output valid, mode, vertex_index, coord_x, coord_y, last_point,
                    input ready);
    modport sink   (input valid, mode, vertex_index, coord_x, coord_y, last_point,
                    output ready);
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic last_result;

    modport source (output valid, inside_res, last_result, input ready);
    modport sink   (input valid, inside_res, last_result, output ready);
endinterface

interface pip_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pip_pkg::COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/pip_cell.sv
// One chain cell: holds a vertex and tests the edge to the next vertex.
module pip_cell #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  pip_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_wr_en,
    input  logic signed [COORD_WIDTH-1:0] i_wr_x,
    input  logic signed [COORD_WIDTH-1:0] i_wr_y,
    input  logic signed [COORD_WIDTH-1:0] i_nbr_x,
    input  logic signed [COORD_WIDTH-1:0] i_nbr_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  pip_pkg::t_tok                 i_tok,
    input  logic signed [COORD_WIDTH-1:0] i_tx,
    input  logic signed [COORD_WIDTH-1:0] i_ty,
    output pip_pkg::t_tok                 o_tok,
    output logic signed [COORD_WIDTH-1:0] o_tx,
    output logic signed [COORD_WIDTH-1:0] o_ty,
    output logic signed [COORD_WIDTH-1:0] o_vx,
    output logic signed [COORD_WIDTH-1:0] o_vy
);
    import pip_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_WIDTH-1:0] r_vx, r_vy;

    logic signed [DW-1:0] w_xa, w_ya, w_xb, w_yb, w_tx, w_ty;
    logic                 w_spans, w_neg;
    logic                 n_s1_hit;
    logic signed [DW-1:0] n_s1_dxt, n_s1_dxe, n_s1_ddy, n_s1_dyt;
    logic signed [PW-1:0] n_s2_pl, n_s2_pr;
    t_tok                 n_s3_tok;

    t_tok                          r_s1_tok, r_s2_tok, r_s3_tok;
    logic                          r_s1_hit, r_s2_hit;
    logic signed [DW-1:0]          r_s1_dxt, r_s1_dxe, r_s1_ddy, r_s1_dyt;
    logic signed [PW-1:0]          r_s2_pl, r_s2_pr;
    logic signed [COORD_WIDTH-1:0] r_s1_tx, r_s1_ty, r_s2_tx, r_s2_ty, r_s3_tx, r_s3_ty;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_vx <= i_wr_x;
            r_vy <= i_wr_y;
        end
    end

    // Stage 1: span test and differences, y difference folded positive
    always_comb begin
        w_xa = {r_vx[COORD_WIDTH-1], r_vx};
        w_ya = {r_vy[COORD_WIDTH-1], r_vy};
        w_xb = i_ctl.wrap ? {i_first_x[COORD_WIDTH-1], i_first_x}
                          : {i_nbr_x[COORD_WIDTH-1], i_nbr_x};
        w_yb = i_ctl.wrap ? {i_first_y[COORD_WIDTH-1], i_first_y}
                          : {i_nbr_y[COORD_WIDTH-1], i_nbr_y};
        w_tx = {i_tx[COORD_WIDTH-1], i_tx};
        w_ty = {i_ty[COORD_WIDTH-1], i_ty};
        w_spans  = ((w_ya <= w_ty) && (w_ty < w_yb)) || ((w_yb <= w_ty) && (w_ty < w_ya));
        w_neg    = w_yb < w_ya;
        n_s1_hit = i_ctl.active && w_spans;
        n_s1_dxt = w_tx - w_xa;
        n_s1_dxe = w_xb - w_xa;
        n_s1_ddy = w_neg ? (w_ya - w_yb) : (w_yb - w_ya);
        n_s1_dyt = w_neg ? (w_ya - w_ty) : (w_ty - w_ya);
    end

    // Stage 2: cross products
    always_comb begin
        n_s2_pl = PW'(r_s1_dxt) * PW'(r_s1_ddy);
        n_s2_pr = PW'(r_s1_dxe) * PW'(r_s1_dyt);
    end

    // Stage 3: point strictly left of the crossing flips the parity
    always_comb begin
        n_s3_tok        = r_s2_tok;
        n_s3_tok.parity = r_s2_tok.parity ^ (r_s2_hit && (r_s2_pl < r_s2_pr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tok <= '0;
            r_s2_tok <= '0;
            r_s3_tok <= '0;
        end else if (i_adv) begin
            r_s1_tok <= i_tok;
            r_s2_tok <= r_s1_tok;
            r_s3_tok <= n_s3_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_hit <= n_s1_hit;
            r_s1_dxt <= n_s1_dxt;
            r_s1_dxe <= n_s1_dxe;
            r_s1_ddy <= n_s1_ddy;
            r_s1_dyt <= n_s1_dyt;
            r_s1_tx  <= i_tx;
            r_s1_ty  <= i_ty;
            r_s2_hit <= r_s1_hit;
            r_s2_pl  <= n_s2_pl;
            r_s2_pr  <= n_s2_pr;
            r_s2_tx  <= r_s1_tx;
            r_s2_ty  <= r_s1_ty;
            r_s3_tx  <= r_s2_tx;
            r_s3_ty  <= r_s2_ty;
        end
    end

    assign o_tok = r_s3_tok;
    assign o_tx  = r_s3_tx;
    assign o_ty  = r_s3_ty;
    assign o_vx  = r_vx;
    assign o_vy  = r_vy;

endmodule

### rtl/core/point_in_polygon_test_core.sv
// Point-in-polygon test core (crossing-number rule) built as a chain of edge cells.
// Cell k holds vertex k and tests the edge from vertex k to vertex k+1, or back to
// vertex 0 for the last vertex in use; a query point walks the whole chain of
// MAX_VERTICES cells, three register stages per cell (differences, products, compare),
// and its result leaves through the output register whatever the vertex count. Points
// stream in one per cycle and a stalled result holds the whole chain. A vertex load
// is taken only once every point in flight has delivered its result. Points on the
// boundary can report inside or outside; a vertex count of zero reports every point
// outside.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_in_if.sink    i_in,
    pip_cfg_if.sink   i_cfg,
    pip_out_if.source o_out
);
    import pip_pkg::*;

    localparam int LP_CAP   = STAGES_PER_CELL * MAX_VERTICES + 1;
    localparam int LP_CNT_W = $clog2(LP_CAP + 1);

    logic [COUNT_W-1:0]  r_vcount;
    logic [LP_CNT_W-1:0] r_inflight;
    logic                r_out_valid;
    logic                r_out_inside;
    logic                r_out_last;

    logic w_is_test, w_adv, w_pt_acc, w_ld_acc, w_out_acc;

    t_tok                          w_tok [MAX_VERTICES+1];
    logic signed [COORD_WIDTH-1:0] w_tx  [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_ty  [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_vx  [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_vy  [MAX_VERTICES];
    t_cell_ctl                     w_ctl [MAX_VERTICES];
    logic                          w_wr_en [MAX_VERTICES];

    assign w_is_test = (i_in.mode == MODE_TEST);
    assign w_adv     = !r_out_valid || o_out.ready;
    // Loads wait for an empty chain so points see the polygon as it was when taken
    assign i_in.ready = w_is_test ? w_adv : (r_inflight == '0);
    assign w_pt_acc   = i_in.valid && i_in.ready && w_is_test;
    assign w_ld_acc   = i_in.valid && i_in.ready && !w_is_test;
    assign w_out_acc  = o_out.valid && o_out.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg.valid) begin
            r_vcount <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({w_pt_acc, w_out_acc})
                2'b10:   r_inflight <= r_inflight + LP_CNT_W'(1);
                2'b01:   r_inflight <= r_inflight - LP_CNT_W'(1);
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    assign w_tok[0] = '{valid: w_pt_acc, parity: 1'b0, last: i_in.last_point};
    assign w_tx[0]  = i_in.coord_x[COORD_WIDTH-1:0];
    assign w_ty[0]  = i_in.coord_y[COORD_WIDTH-1:0];

    for (genvar K = 0; K < MAX_VERTICES; K++) begin : g_cell
        assign w_ctl[K].active = (K < int'(r_vcount));
        assign w_ctl[K].wrap   = (K == MAX_VERTICES - 1) || (K + 1 == int'(r_vcount));
        assign w_wr_en[K]      = w_ld_acc && (int'(i_in.vertex_index) == K);

        if (K == MAX_VERTICES - 1) begin : g_tail
            pip_cell #(
                .COORD_WIDTH(COORD_WIDTH)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (w_adv),
                .i_ctl    (w_ctl[K]),
                .i_wr_en  (w_wr_en[K]),
                .i_wr_x   (i_in.coord_x[COORD_WIDTH-1:0]),
                .i_wr_y   (i_in.coord_y[COORD_WIDTH-1:0]),
                .i_nbr_x  (w_vx[0]),
                .i_nbr_y  (w_vy[0]),
                .i_first_x(w_vx[0]),
                .i_first_y(w_vy[0]),
                .i_tok    (w_tok[K]),
                .i_tx     (w_tx[K]),
                .i_ty     (w_ty[K]),
                .o_tok    (w_tok[K+1]),
                .o_tx     (),
                .o_ty     (),
                .o_vx     (w_vx[K]),
                .o_vy     (w_vy[K])
            );
        end else begin : g_body
            pip_cell #(
                .COORD_WIDTH(COORD_WIDTH)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (w_adv),
                .i_ctl    (w_ctl[K]),
                .i_wr_en  (w_wr_en[K]),
                .i_wr_x   (i_in.coord_x[COORD_WIDTH-1:0]),
                .i_wr_y   (i_in.coord_y[COORD_WIDTH-1:0]),
                .i_nbr_x  (w_vx[K+1]),
                .i_nbr_y  (w_vy[K+1]),
                .i_first_x(w_vx[0]),
                .i_first_y(w_vy[0]),
                .i_tok    (w_tok[K]),
                .i_tx     (w_tx[K]),
                .i_ty     (w_ty[K]),
                .o_tok    (w_tok[K+1]),
                .o_tx     (w_tx[K+1]),
                .o_ty     (w_ty[K+1]),
                .o_vx     (w_vx[K]),
                .o_vy     (w_vy[K])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok[MAX_VERTICES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_inside <= w_tok[MAX_VERTICES].parity;
            r_out_last   <= w_tok[MAX_VERTICES].last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.inside_res  = r_out_inside;
    assign o_out.last_result = r_out_last;

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_load_empty, i_clk, i_rst_n, w_ld_acc, r_inflight == '0)
    `ASSERT_IMPLY(a_out_counted, i_clk, i_rst_n, r_out_valid, r_inflight != '0)
    `ASSERT_IMPLY(a_cnt_cap, i_clk, i_rst_n, w_pt_acc, r_inflight <= LP_CNT_W'(LP_CAP))
    `ASSERT_NEXT(a_first_pt, i_clk, i_rst_n, w_pt_acc && (r_inflight == '0), r_inflight == LP_CNT_W'(1))

endmodule

### test/point_in_polygon_test_core_test.sv
// Self-checking bench for the point-in-polygon core: loads polygons, streams query points.
module point_in_polygon_test_core_test;
    import pip_pkg::*;

    localparam int MAX_V        = MAX_VERTICES_DEF;
    localparam int DRAIN_CYCLES = 3 * MAX_V + 40;
    localparam int LONG_HOLD    = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int N_PHASES     = 12;
    localparam int PRESS_PHASE  = 7;
    localparam int BOX_SPAN     = 1 << 20;
    localparam int GRID_STEP    = 1 << 26;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_BOX,
        SPREAD_GRID
    } t_spread;

    typedef struct {
        t_mode                     mode;
        logic [IDX_W-1:0]          slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_poly_op;

    typedef struct {
        logic in_poly;
        logic last;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pip_in_if  point_if ();
    pip_cfg_if count_if ();
    pip_out_if verdict_if ();

    point_in_polygon_test_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (point_if),
        .i_cfg   (count_if),
        .o_out   (verdict_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pending loads and queries, and the verdicts still owed by the block
    t_poly_op ops_q[$];
    t_verdict verdict_q[$];
    t_poly_op op_on_bus;

    // predictor copy of the block state
    logic signed [COORD_W-1:0] vx_mem [MAX_V];
    logic signed [COORD_W-1:0] vy_mem [MAX_V];
    logic [COUNT_W-1:0]        poly_count;

    // what the stimulus side has loaded so far
    logic signed [COORD_W-1:0] gen_x [MAX_V];
    logic signed [COORD_W-1:0] gen_y [MAX_V];
    bit [MAX_V-1:0]            gen_loaded;

    int  send_idle_pct, take_idle_pct;
    int  send_gap, take_gap, hold_left;
    bit  hold_go, hold_done;
    int  mismatch_cnt, loads_taken, tests_taken, n_inside, n_outside, settings_written;

    // Even-odd rule over the edges in use, compared exactly by cross-multiplication.
    function automatic logic crossing_parity(input logic signed [COORD_W-1:0] px_in,
                                             input logic signed [COORD_W-1:0] py_in);
        int                 n, j;
        logic               par;
        logic signed [71:0] px, py, xi, yi, xj, yj, ddy, dyt;
        n   = (poly_count > MAX_V) ? MAX_V : int'(poly_count);
        par = 1'b0;
        px  = 72'(px_in);
        py  = 72'(py_in);
        if (n == 0)
            return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = 72'(vx_mem[i]);
            yi = 72'(vy_mem[i]);
            xj = 72'(vx_mem[j]);
            yj = 72'(vy_mem[j]);
            if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
                ddy = yj - yi;
                dyt = py - yi;
                // fold the sign of the y difference into both sides
                if (ddy < 0) begin
                    ddy = -ddy;
                    dyt = -dyt;
                end
                if ((px - xi) * ddy < (xj - xi) * dyt)
                    par = ~par;
            end
            j = i;
        end
        return par;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input t_spread spread);
        case (spread)
            SPREAD_BOX:  return $signed($urandom_range(2 * BOX_SPAN, 0)) - BOX_SPAN;
            SPREAD_GRID: return (int'($urandom_range(8, 0)) - 4) * GRID_STEP;
            default:     return $urandom();
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 5;
            2:       return 15;
            default: return 35;
        endcase
    endfunction

    task automatic push_vertex(input int slot, input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        ops_q.push_back('{MODE_LOAD, IDX_W'(slot), x, y, 1'($urandom_range(1, 0))});
        gen_x[slot]      = x;
        gen_y[slot]      = y;
        gen_loaded[slot] = 1'b1;
    endtask

    task automatic push_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic last);
        ops_q.push_back('{MODE_TEST, IDX_W'($urandom_range(MAX_V - 1, 0)), x, y, last});
    endtask

    task automatic drain_block();
        do @(negedge i_clk);
        while (ops_q.size() != 0 || point_if.valid || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
        @(posedge i_clk);
        count_if.valid <= 1'b1;
        count_if.data  <= value;
        do @(posedge i_clk);
        while (!count_if.ready);
        count_if.valid <= 1'b0;
        poly_count = value;
        settings_written++;
    endtask

    // Driver: present queued items, predict each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_if.valid        <= 1'b0;
            point_if.mode         <= MODE_LOAD;
            point_if.vertex_index <= '0;
            point_if.coord_x      <= '0;
            point_if.coord_y      <= '0;
            point_if.last_point   <= 1'b0;
            send_gap              <= 0;
        end else begin
            if (point_if.valid && point_if.ready) begin
                if (op_on_bus.mode == MODE_LOAD) begin
                    vx_mem[op_on_bus.slot] = op_on_bus.x;
                    vy_mem[op_on_bus.slot] = op_on_bus.y;
                    loads_taken++;
                end else begin
                    verdict_q.push_back('{crossing_parity(op_on_bus.x, op_on_bus.y),
                                          op_on_bus.last});
                    tests_taken++;
                end
            end
            if (!point_if.valid || point_if.ready) begin
                if (send_gap != 0) begin
                    send_gap       <= send_gap - 1;
                    point_if.valid <= 1'b0;
                end else if (ops_q.size() != 0 && $urandom_range(99, 0) < send_idle_pct) begin
                    send_gap       <= $urandom_range(12, 0);
                    point_if.valid <= 1'b0;
                end else if (ops_q.size() != 0) begin
                    op_on_bus = ops_q.pop_front();
                    point_if.mode         <= op_on_bus.mode;
                    point_if.vertex_index <= op_on_bus.slot;
                    point_if.coord_x      <= op_on_bus.x;
                    point_if.coord_y      <= op_on_bus.y;
                    point_if.last_point   <= op_on_bus.last;
                    point_if.valid        <= 1'b1;
                end else begin
                    point_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each verdict against the oldest prediction, pace ready.
    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (!i_rst_n) begin
            verdict_if.ready <= 1'b0;
            take_gap         <= 0;
            hold_left        <= 0;
            hold_done        <= 1'b0;
        end else begin
            if (verdict_if.valid && verdict_if.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with none expected: inside_res=%0b last_result=%0b",
                             $time, verdict_if.inside_res, verdict_if.last_result);
                    mismatch_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (verdict_if.inside_res !== want.in_poly) begin
                        $display("%0t: inside_res expected %0b actual %0b",
                                 $time, want.in_poly, verdict_if.inside_res);
                        mismatch_cnt++;
                    end
                    if (verdict_if.last_result !== want.last) begin
                        $display("%0t: last_result expected %0b actual %0b",
                                 $time, want.last, verdict_if.last_result);
                        mismatch_cnt++;
                    end
                    if (want.in_poly)
                        n_inside++;
                    else
                        n_outside++;
                end
            end
            if (hold_left != 0) begin
                hold_left        <= hold_left - 1;
                verdict_if.ready <= 1'b0;
            end else if (hold_go && !hold_done) begin
                // long hold-off: let the chain fill and back-pressure the input
                hold_done        <= 1'b1;
                hold_left        <= LONG_HOLD - 1;
                verdict_if.ready <= 1'b0;
            end else if (take_gap != 0) begin
                take_gap         <= take_gap - 1;
                verdict_if.ready <= 1'b0;
            end else if ($urandom_range(99, 0) < take_idle_pct) begin
                take_gap         <= $urandom_range(12, 0);
                verdict_if.ready <= 1'b0;
            end else begin
                verdict_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((ops_q.size() != 0 || verdict_q.size() != 0 || point_if.valid
                 || count_if.valid)
                && !(point_if.valid && point_if.ready)
                && !(verdict_if.valid && verdict_if.ready)
                && !(count_if.valid && count_if.ready))
                quiet++;
            else
                quiet = 0;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [COUNT_W-1:0] cnt;
        int                 n_use, n_tests, r, k;
        bit                 all_set;
        t_spread            spread;
        logic               last;

        i_rst_n               = 1'b0;
        point_if.valid        = 1'b0;
        point_if.mode         = MODE_LOAD;
        point_if.vertex_index = '0;
        point_if.coord_x      = '0;
        point_if.coord_y      = '0;
        point_if.last_point   = 1'b0;
        count_if.valid        = 1'b0;
        count_if.data         = '0;
        verdict_if.ready      = 1'b0;
        poly_count            = '0;
        gen_loaded            = '0;
        send_idle_pct         = 10;
        take_idle_pct         = 10;
        hold_go               = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty polygon: load the full-range square, every point must come back outside
        write_vertex_count(0);
        push_vertex(0, C_MIN, C_MIN);
        push_vertex(1, C_MAX, C_MIN);
        push_vertex(2, C_MAX, C_MAX);
        push_vertex(3, C_MIN, C_MAX);
        push_vertex(MAX_V - 1, 32'sh5555_5555, 32'shAAAA_AAAA);
        push_point(0, 0, 1'b0);
        push_point(C_MIN, C_MAX, 1'b1);
        drain_block();

        // full-range square: centre, two corners and each side
        write_vertex_count(4);
        push_point(0, 0, 1'b0);
        push_point(C_MAX, C_MAX, 1'b0);
        push_point(C_MIN, C_MIN, 1'b0);
        push_point(C_MIN, 0, 1'b0);
        push_point(C_MAX, 0, 1'b0);
        push_point(0, C_MAX, 1'b0);
        push_point(0, C_MIN, 1'b0);
        push_point(32'shAAAA_AAAA, 32'sh5555_5555, 1'b1);
        drain_block();

        // triangle with a horizontal side and a sloped one
        write_vertex_count(3);
        push_vertex(0, 0, 0);
        push_vertex(1, 10 * C_ONE, 0);
        push_vertex(2, 0, 10 * C_ONE);
        push_point(C_ONE, C_ONE, 1'b0);
        push_point(5 * C_ONE, 0, 1'b0);
        push_point(5 * C_ONE, 5 * C_ONE, 1'b0);
        push_point(-1, C_ONE, 1'b1);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_block();
            case (ph)
                0:       cnt = 64;
                1:       cnt = 127;
                2:       cnt = 1;
                3:       cnt = 2;
                4:       cnt = 65;
                5:       cnt = 3;
                PRESS_PHASE: cnt = 4;
                default: cnt = ($urandom_range(3, 0) == 0) ? COUNT_W'($urandom_range(127, 0))
                                                           : COUNT_W'($urandom_range(12, 3));
            endcase
            if (ph >= N_PHASES - 2) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else begin
                send_idle_pct = pick_idle_pct();
                take_idle_pct = pick_idle_pct();
            end
            write_vertex_count(cnt);
            n_use  = (cnt > MAX_V) ? MAX_V : int'(cnt);
            spread = t_spread'($urandom_range(2, 0));

            // reload the polygon if any slot in use is unwritten, and otherwise at random
            all_set = 1'b1;
            for (int s = 0; s < n_use; s++)
                if (!gen_loaded[s])
                    all_set = 1'b0;
            if (!all_set || $urandom_range(3, 0) != 0)
                for (int s = 0; s < n_use; s++)
                    push_vertex(s, pick_coord(spread), pick_coord(spread));

            if (ph == PRESS_PHASE)
                hold_go = 1'b1;
            n_tests = (ph == PRESS_PHASE) ? 260 : $urandom_range(40, 25);
            for (int t = 0; t < n_tests; t++) begin
                r    = $urandom_range(15, 0);
                last = (t == n_tests - 1) || ($urandom_range(7, 0) == 0);
                if (r == 0 && t != n_tests - 1) begin
                    push_vertex($urandom_range(MAX_V - 1, 0), pick_coord(spread),
                                pick_coord(spread));
                end else if (r < 3 && n_use != 0) begin
                    // land on a vertex
                    k = $urandom_range(n_use - 1, 0);
                    push_point(gen_x[k], gen_y[k], last);
                end else begin
                    push_point(pick_coord(spread), pick_coord(spread), last);
                end
            end
        end
        drain_block();

        $display("Covered %0d vertex loads and %0d point tests over %0d vertex-count writes",
                 loads_taken, tests_taken, settings_written);
        $display("Verdicts checked: %0d inside, %0d outside, %0d mismatches",
                 n_inside, n_outside, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
